/* design/itor_pkg.sv */
package itor_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned VALUE_FIELD_W = 64;
  localparam int unsigned RADIX_FIELD_W = 8;
  localparam int unsigned CHAR_W        = 8;

  // Default conversion width of the value.
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  // Radix limits and the width of one digit (a digit is below 36).
  localparam logic [RADIX_FIELD_W-1:0] RADIX_MIN = 8'd2;
  localparam logic [RADIX_FIELD_W-1:0] RADIX_MAX = 8'd36;
  localparam int unsigned DIGIT_W = 6;

  // ASCII anchors for the digit alphabet.
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  // Maps a digit value to its character: 0-9 then lowercase letters.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_TEN) begin
      ch = CHAR_ZERO + {2'b00, d};
    end else begin
      ch = CHAR_LOWER_A + {2'b00, d - DIGIT_TEN};
    end
    return ch;
  endfunction

endpackage

/* design/itor_in_if.sv */
interface itor_in_if;

  logic                                      valid;
  logic                                      ready;
  logic signed [itor_pkg::VALUE_FIELD_W-1:0] value;
  logic        [itor_pkg::RADIX_FIELD_W-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);

endinterface

/* design/itor_out_if.sv */
interface itor_out_if;

  logic                         valid;
  logic                         ready;
  logic [itor_pkg::CHAR_W-1:0]  char_code;
  logic                         negative;
  logic                         radix_bad;
  logic                         last;

  modport source (output valid, output char_code, output negative, output radix_bad,
                  output last, input ready);
  modport sink   (input valid, input char_code, input negative, input radix_bad,
                  input last, output ready);

endinterface

/* design/integer_to_radix_digits_core.sv */
// Operation: a value's digits come one by one from bit-serial division after the input
// beat, then its first character is shown; a bad radix skips division and shows '0'.
// Flow: the restoring divider handles one quotient bit per cycle, and a new input beat
// is taken only once every character of the last item has been shown.
// Reset: rst_ni clears the control state asynchronously; the digit stack needs no
// clearing, so the block is ready for an input beat as soon as reset ends.
module integer_to_radix_digits_core #(
  parameter int unsigned VALUE_WIDTH = itor_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  itor_in_if.sink       in_i,
  itor_out_if.source    out_o
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned DW = itor_pkg::DIGIT_W;
  localparam int unsigned BW = $clog2(VW);
  localparam int unsigned CW = $clog2(VW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [BW-1:0]   bit_q, bit_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [VW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   radix_q, radix_d;
  logic            neg_q, neg_d;
  logic            bad_q, bad_d;
  logic [DW-1:0]   stack_q [VW];

  logic            in_fire, out_fire;
  logic            radix_ok;
  logic [VW-1:0]   raw;
  logic [VW-1:0]   mag;
  logic [DW:0]     trial;
  logic            take;
  logic [DW-1:0]   rem_next;
  logic [VW-1:0]   quo_next;
  logic            last_step;
  logic            push, pop;
  logic [DW-1:0]   push_digit;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  // Input decode: radix check and two's complement magnitude of the low bits.
  assign radix_ok = (in_i.radix >= itor_pkg::RADIX_MIN) && (in_i.radix <= itor_pkg::RADIX_MAX);
  assign raw      = in_i.value[VW-1:0];
  assign mag      = raw[VW-1] ? (~raw + {{(VW-1){1'b0}}, 1'b1}) : raw;

  // One restoring division step: bring down the next quotient bit.
  assign trial     = {rem_q, quo_q[VW-1]};
  assign take      = trial >= {1'b0, radix_q};
  assign rem_next  = take ? DW'(trial - {1'b0, radix_q}) : trial[DW-1:0];
  assign quo_next  = {quo_q[VW-2:0], take};
  assign last_step = (bit_q == BW'(VW - 1));

  // Control and datapath next state.
  always_comb begin
    state_d    = state_q;
    bit_d      = bit_q;
    cnt_d      = cnt_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    radix_d    = radix_q;
    neg_d      = neg_q;
    bad_d      = bad_q;
    push       = 1'b0;
    pop        = 1'b0;
    push_digit = rem_next;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          bit_d   = '0;
          rem_d   = '0;
          radix_d = in_i.radix[DW-1:0];
          if (radix_ok) begin
            quo_d   = mag;
            neg_d   = raw[VW-1];
            bad_d   = 1'b0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end else begin
            // A bad radix gives a lone zero digit.
            neg_d      = 1'b0;
            bad_d      = 1'b1;
            push       = 1'b1;
            push_digit = '0;
            cnt_d      = CW'(1);
            state_d    = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (last_step) begin
          // The remainder is the next digit, least significant first.
          push  = 1'b1;
          cnt_d = cnt_q + CW'(1);
          quo_d = quo_next;
          rem_d = '0;
          bit_d = '0;
          if (quo_next == '0) begin
            state_d = ST_EMIT;
          end
        end else begin
          quo_d = quo_next;
          rem_d = rem_next;
          bit_d = bit_q + BW'(1);
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          pop   = 1'b1;
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    neg_q   <= neg_d;
    bad_q   <= bad_d;
  end

  // Digit stack: a push shifts towards the bottom, so the top holds the most
  // significant digit once division ends; a pop shifts back up.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= push_digit;
      for (int i = 1; i < VW; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VW - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  // Handshake and result fields.
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = (state_q == ST_EMIT);
  assign out_o.char_code = itor_pkg::digit_char(stack_q[0]);
  assign out_o.negative  = neg_q;
  assign out_o.radix_bad = bad_q;
  assign out_o.last      = (cnt_q == CW'(1));

endmodule
